// ===== src/cst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and helpers for the token scanner
// Token kinds, scanner modes, the result record, the character classes
// and the keyword match used by the scanner and its result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  localparam int CHAR_W       = 8;
  localparam int KIND_W       = 5;
  localparam int LEN_W        = 5;
  localparam int PREFIX_DEPTH = 5;
  localparam int PREFIX_IDX_W = 3;
  localparam int LENGTH_LIMIT = 31;
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((LENGTH_LIMIT < 31) ? LENGTH_LIMIT : 31);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT  = 5'd0,
    KIND_VOID   = 5'd1,
    KIND_INT    = 5'd2,
    KIND_FLOAT  = 5'd3,
    KIND_CHAR   = 5'd4,
    KIND_COMMA  = 5'd5,
    KIND_COLON  = 5'd6,
    KIND_LPAREN = 5'd7,
    KIND_RPAREN = 5'd8,
    KIND_ASSIGN = 5'd9,
    KIND_SEMI   = 5'd10,
    KIND_LBRACE = 5'd11,
    KIND_RBRACE = 5'd12,
    KIND_PLUS   = 5'd13,
    KIND_INCR   = 5'd14,
    KIND_STAR   = 5'd15,
    KIND_MINUS  = 5'd16,
    KIND_END    = 5'd17,
    KIND_NUL    = 5'd18,
    KIND_ERROR  = 5'd19
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_PLUS = 2'd2
  } scan_mode_t;

  typedef struct packed {
    token_kind_t      kind;
    logic [LEN_W-1:0] length;
    logic             last;
  } token_t;

  // Results of one accepted character, handed to the result queue.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_req_t;

  typedef logic [PREFIX_DEPTH-1:0][CHAR_W-1:0] prefix_t;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ASSIGN = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  function automatic logic is_start(input logic [CHAR_W-1:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDER);
  endfunction

  function automatic logic is_part(input logic [CHAR_W-1:0] c);
    return is_start(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  // Single-character tokens; anything not listed is a lexical error.
  function automatic token_kind_t single_kind(input logic [CHAR_W-1:0] c);
    token_kind_t k;
    case (c)
      CH_COMMA:  k = KIND_COMMA;
      CH_COLON:  k = KIND_COLON;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_ASSIGN: k = KIND_ASSIGN;
      CH_SEMI:   k = KIND_SEMI;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_STAR:   k = KIND_STAR;
      CH_MINUS:  k = KIND_MINUS;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Keyword match on the stored prefix. Only entries below the length are
  // compared, so stale entries never matter.
  function automatic token_kind_t word_kind(input prefix_t p,
                                            input logic [LEN_W-1:0] len);
    token_kind_t k;
    k = KIND_IDENT;
    if (len == LEN_W'(4) && p[0] == "v" && p[1] == "o" && p[2] == "i" &&
        p[3] == "d") begin
      k = KIND_VOID;
    end else if (len == LEN_W'(3) && p[0] == "i" && p[1] == "n" &&
                 p[2] == "t") begin
      k = KIND_INT;
    end else if (len == LEN_W'(5) && p[0] == "f" && p[1] == "l" &&
                 p[2] == "o" && p[3] == "a" && p[4] == "t") begin
      k = KIND_FLOAT;
    end else if (len == LEN_W'(4) && p[0] == "c" && p[1] == "h" &&
                 p[2] == "a" && p[3] == "r") begin
      k = KIND_CHAR;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== src/cst_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_char_if: character channel
// Valid/ready channel that carries one source byte or an end-of-input mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input,
                  input ready);
  modport sink (input valid, input char_code, input end_of_input,
                output ready);
endinterface

`default_nettype wire

// ===== src/cst_token_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_token_if: token channel
// Valid/ready channel that carries one token kind and length.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_token_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [4:0] token_length;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_length,
                input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/cst_result_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_result_queue: four-entry token queue
// Takes up to two tokens per cycle and presents them one per cycle on the
// token channel when ready. Room is reported while at least two are free.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_result_queue
  import cst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire push_req_t push,
  output logic           room,
  cst_token_if.source    token_out
);

  token_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;

  assign pop  = token_out.valid && token_out.ready;
  assign room = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  assign token_out.valid        = (count != '0);
  assign token_out.token_kind   = entry[rd_ptr].kind;
  assign token_out.token_length = entry[rd_ptr].length;
  assign token_out.last_of_run  = entry[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entry[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/c_subset_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner_unit: token scanner for a small C subset
// Turns a byte stream into identifier, keyword, punctuator and marker tokens.
// ----------------------------------------------------------------------------
// Usage:
// The char_in channel takes one request per cycle while there is room: a
// source byte, or an end-of-input mark (the byte is then ignored). The
// token_out channel gives the token kind and its length; last_of_run flags
// the final token that a request caused. A request causes zero, one or two
// tokens: an identifier or a pending '+' is sent when the next character
// ends it, followed by the token of that character itself. An end mark
// flushes the pending token and then gives an end token of length zero.
// Tokens of a request accepted at an edge are offered from the next cycle
// on. Characters are taken at one per cycle while the four-entry result
// queue has room; it accepts a request only while two entries are free,
// so a request that causes two tokens offers them one after the other.
// When the receiver stalls the queue fills and char_in.ready drops;
// nothing is lost or repeated. Reset empties the queue, returns the
// scanner to idle and clears the identifier length; the stored identifier
// prefix is not cleared, as only entries below the length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_token_scanner_unit
  import cst_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  cst_char_if.sink    char_in,
  cst_token_if.source token_out
);

  // Scanner state.
  scan_mode_t        mode;
  scan_mode_t        mode_next;
  logic [LEN_W-1:0]  word_length;
  logic [LEN_W-1:0]  word_length_next;
  prefix_t           word_prefix;

  // Prefix write request from the next-state logic.
  logic                    prefix_we;
  logic [PREFIX_IDX_W-1:0] prefix_idx;

  logic        accept;
  logic        room;
  logic [7:0]  c;
  logic        eoi;

  // The pending token is the one closed by this character; the tail token
  // is the one the character produces on its own.
  logic        pend_valid;
  token_t      pend_tok;
  logic        tail_valid;
  token_t      tail_tok;
  logic        from_idle;
  push_req_t   push;

  assign c              = char_in.char_code;
  assign eoi            = char_in.end_of_input;
  assign char_in.ready  = room;
  assign accept         = char_in.valid && room;

  // A word continues while part characters arrive; '+' waits for one more
  // character. Every other case falls through to the idle handling.
  always_comb begin
    from_idle = 1'b1;
    case (mode)
      MODE_WORD: begin
        from_idle = eoi || !is_part(c);
      end
      MODE_PLUS: begin
        from_idle = eoi || (c != CH_PLUS);
      end
      default: begin
        from_idle = 1'b1;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    mode_next        = MODE_IDLE;
    word_length_next = '0;
    prefix_we        = 1'b0;
    prefix_idx       = '0;
    if (!from_idle) begin
      if (mode == MODE_WORD) begin
        mode_next        = MODE_WORD;
        prefix_we        = (word_length < LEN_W'(PREFIX_DEPTH));
        prefix_idx       = word_length[PREFIX_IDX_W-1:0];
        word_length_next = (word_length < LEN_CAP) ?
                           word_length + LEN_W'(1) : word_length;
      end
    end else if (!eoi) begin
      if (is_start(c)) begin
        mode_next        = MODE_WORD;
        prefix_we        = 1'b1;
        prefix_idx       = '0;
        word_length_next = LEN_W'(1);
      end else if (c == CH_PLUS) begin
        mode_next = MODE_PLUS;
      end
    end
  end

  // Token outputs.
  always_comb begin
    pend_valid = 1'b0;
    pend_tok   = '{kind: KIND_IDENT, length: '0, last: 1'b0};
    tail_valid = 1'b0;
    tail_tok   = '{kind: KIND_ERROR, length: LEN_W'(1), last: 1'b1};
    case (mode)
      MODE_WORD: begin
        pend_valid      = from_idle;
        pend_tok.kind   = word_kind(word_prefix, word_length);
        pend_tok.length = word_length;
      end
      MODE_PLUS: begin
        pend_valid      = 1'b1;
        pend_tok.kind   = from_idle ? KIND_PLUS : KIND_INCR;
        pend_tok.length = from_idle ? LEN_W'(1) : LEN_W'(2);
      end
      default: begin
        pend_valid = 1'b0;
      end
    endcase

    if (from_idle) begin
      if (eoi) begin
        tail_valid      = 1'b1;
        tail_tok.kind   = KIND_END;
        tail_tok.length = '0;
      end else if (c == CH_NUL) begin
        tail_valid    = 1'b1;
        tail_tok.kind = KIND_NUL;
      end else if (!is_start(c) && c != CH_PLUS && !is_space(c)) begin
        tail_valid    = 1'b1;
        tail_tok.kind = single_kind(c);
      end
    end

    pend_tok.last = !tail_valid;

    push.count  = 2'd0;
    push.first  = pend_valid ? pend_tok : tail_tok;
    push.second = tail_tok;
    if (accept) begin
      push.count = 2'(pend_valid) + 2'(tail_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      word_length <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      word_length <= word_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && prefix_we) begin
      word_prefix[prefix_idx] <= c;
    end
  end

  cst_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .token_out (token_out)
  );

endmodule

`default_nettype wire
